>>> sv/trt_pkg.sv
// ============================================================================
// trt_pkg
// Shared types and codes for the touch report tracker: the input and result
// words, finger status codes, result kinds and the pending result record.
// ============================================================================
package trt_pkg;

    localparam int unsigned NumFingers = 2;
    localparam int unsigned NumKeys    = 2;
    localparam int unsigned NumSlots   = 5;    // key0, key1, finger0, finger1, sync

    // Position of each result in the pending mask, in emission order.
    localparam int unsigned SlotKey0    = 0;
    localparam int unsigned SlotKey1    = 1;
    localparam int unsigned SlotFinger0 = 2;
    localparam int unsigned SlotFinger1 = 3;
    localparam int unsigned SlotSync    = 4;

    // Bit of the status byte that carries key 0; key 1 is the next bit up.
    localparam int unsigned KeyBitBase = 6;

    typedef enum logic [1:0] {
        FS_RELEASED = 2'd0,
        FS_PRESSED  = 2'd1,
        FS_IDLE     = 2'd2
    } t_finger;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_CONTACT = 2'd1,
        KIND_SYNC    = 2'd2
    } t_kind;

    typedef struct packed {
        logic        read_ok;
        logic [7:0]  status_byte;
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic [7:0]  first_size;
        logic [7:0]  id_pair;
        logic [15:0] second_x;
        logic [15:0] second_y;
        logic [7:0]  second_size;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic        slot;
        logic        key_down;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        touch_level;
        logic [7:0]  contact_size;
        logic        last;
    } t_out_word;

    // Everything needed to emit one report's results.
    typedef struct packed {
        logic [NumSlots-1:0]        mask;    // results still to send
        logic [NumKeys-1:0]         key_now;
        logic [NumFingers-1:0]      level;
        logic [NumFingers-1:0][15:0] x;
        logic [NumFingers-1:0][15:0] y;
        logic [NumFingers-1:0][7:0]  size;
    } t_pend;

endpackage

>>> sv/trt_step.sv
// ============================================================================
// trt_step
// Per-report update: steps key and finger status and builds the set of
// results the report produces.
// ============================================================================
module trt_step (
    input  trt_pkg::t_in_word                  i_word,
    input  trt_pkg::t_finger [1:0]             i_finger,
    input  logic [1:0]                         i_key,
    output trt_pkg::t_finger [1:0]             o_finger_n,
    output logic [1:0]                         o_key_n,
    output trt_pkg::t_pend                     o_pend
);
    import trt_pkg::*;

    logic [1:0][3:0] fid;
    logic [1:0]      keys_in;
    logic            any_pressed;

    assign fid[0]      = i_word.id_pair[7:4];
    assign fid[1]      = i_word.id_pair[3:0];
    assign keys_in     = i_word.status_byte[KeyBitBase +: NumKeys];
    assign any_pressed = (i_finger[0] == FS_PRESSED) || (i_finger[1] == FS_PRESSED);

    always_comb begin
        o_finger_n   = i_finger;
        o_key_n      = i_key;
        o_pend.mask  = '0;
        o_pend.key_now = keys_in;
        o_pend.x     = {i_word.second_x, i_word.first_x};
        o_pend.y     = {i_word.second_y, i_word.first_y};
        o_pend.size  = {i_word.second_size, i_word.first_size};
        o_pend.level = '0;

        if (i_word.read_ok) begin
            // keys are only sampled when no finger was down
            if (!any_pressed) begin
                o_key_n = keys_in;
                o_pend.mask[SlotKey0] = keys_in[0] ^ i_key[0];
                o_pend.mask[SlotKey1] = keys_in[1] ^ i_key[1];
            end

            for (int i = 0; i < NumFingers; i++) begin
                if (fid[i] != 4'd0) begin
                    o_finger_n[i] = FS_PRESSED;
                end else begin
                    unique case (i_finger[i])
                        FS_PRESSED: o_finger_n[i] = FS_RELEASED;
                        default:    o_finger_n[i] = FS_IDLE;
                    endcase
                end
                o_pend.level[i] = (o_finger_n[i] == FS_PRESSED);
                o_pend.mask[SlotFinger0 + i] = (o_finger_n[i] != FS_IDLE);
            end

            o_pend.mask[SlotSync] = 1'b1;
        end
    end

endmodule

>>> sv/touch_report_tracker.sv
// ============================================================================
// touch_report_tracker
// Two-finger touch report tracker: key events, contact reports and a frame
// sync per good report, one result word per cycle while the output is ready.
// ============================================================================
// An accepted report is registered as the pending record, and its results then
// move, lowest slot first, into the single result output register. Throughput:
//   one result word per cycle while the output is ready, set by that register;
//   a report yields 1 to 5 results, a failed read none.
// Reset: fingers return to just released, keys to released, no results pending.
// ============================================================================
module touch_report_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  trt_pkg::t_in_word     i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output trt_pkg::t_out_word    o_out
);
    import trt_pkg::*;

    // Tracker state, updated when a report is accepted.
    t_finger [1:0] r_finger;
    logic [1:0]    r_key;
    t_finger [1:0] n_finger;
    logic [1:0]    n_key;

    // Pending result record for the report being emitted.
    t_pend         r_pend;
    t_pend         step_pend;
    logic [NumSlots-1:0] r_mask;
    logic [NumSlots-1:0] n_mask;
    logic [NumSlots-1:0] sel;
    logic [NumSlots-1:0] mask_left;

    // Result output register.
    t_out_word     r_out;
    t_out_word     n_out;
    logic          r_out_valid;

    logic          in_acc;
    logic          load;

    trt_step u_step (
        .i_word     (i_in),
        .i_finger   (r_finger),
        .i_key      (r_key),
        .o_finger_n (n_finger),
        .o_key_n    (n_key),
        .o_pend     (step_pend)
    );

    // Move the lowest pending result into the output register whenever it
    // is empty or being drained this cycle.
    assign load      = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign sel       = r_mask & (~r_mask + NumSlots'(1));
    assign mask_left = r_mask & ~sel;

    // Take a new report once the current one is fully handed to the output
    // register, even while that word still waits downstream.
    assign o_in_ready = (r_mask == '0) || (load && (mask_left == '0));
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_mask = r_mask;
        if (load) begin
            n_mask = mask_left;
        end
        if (in_acc) begin
            n_mask = step_pend.mask;
        end
    end

    // Result word for the selected slot.
    always_comb begin
        n_out = '0;
        if (sel[SlotKey0]) begin
            n_out.kind     = KIND_KEY;
            n_out.slot     = 1'b0;
            n_out.key_down = r_pend.key_now[0];
        end else if (sel[SlotKey1]) begin
            n_out.kind     = KIND_KEY;
            n_out.slot     = 1'b1;
            n_out.key_down = r_pend.key_now[1];
        end else if (sel[SlotFinger0]) begin
            n_out.kind         = KIND_CONTACT;
            n_out.slot         = 1'b0;
            n_out.pos_x        = r_pend.x[0];
            n_out.pos_y        = r_pend.y[0];
            n_out.touch_level  = r_pend.level[0];
            n_out.contact_size = r_pend.size[0];
        end else if (sel[SlotFinger1]) begin
            n_out.kind         = KIND_CONTACT;
            n_out.slot         = 1'b1;
            n_out.pos_x        = r_pend.x[1];
            n_out.pos_y        = r_pend.y[1];
            n_out.touch_level  = r_pend.level[1];
            n_out.contact_size = r_pend.size[1];
        end else begin
            n_out.kind = KIND_SYNC;
            n_out.last = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finger[0] <= FS_RELEASED;
            r_finger[1] <= FS_RELEASED;
            r_key       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (in_acc) begin
                r_finger <= n_finger;
                r_key    <= n_key;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload, no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend <= step_pend;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Any pending report still owes its frame sync.
    a_sync_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) |-> r_mask[SlotSync])
        else $error("pending results without frame sync");

    // A good report always queues results.
    a_good_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.read_ok) |=> (r_mask != '0))
        else $error("good report produced no results");

    // Keys are frozen while a finger was pressed.
    a_key_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ((r_finger[0] == FS_PRESSED) || (r_finger[1] == FS_PRESSED)))
        |=> $stable(r_key))
        else $error("key state changed while a finger was down");

    // The last flag only ever rides on a frame sync.
    a_last_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |-> (o_out.kind == KIND_SYNC))
        else $error("last flag on a non-sync result");

endmodule
